[design/http_request_framer_core_macros.svh]
// Assertion helpers used by the framer top level
`ifndef HTTP_REQUEST_FRAMER_CORE_MACROS_SVH
`define HTTP_REQUEST_FRAMER_CORE_MACROS_SVH

// Same-cycle implication, quiet while in reset
`define HRF_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hrf: same-cycle check failed");

// Next-cycle implication, quiet while in reset
`define HRF_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hrf: next-cycle check failed");

`endif

[design/hrf_pkg.sv]
package hrf_pkg;

	// Width of the length accumulator and body counter
	localparam int LENGTH_BITS = 32;
	// Width of the reported body length
	localparam int BLEN_W      = 32;

	// Header key "Content-Length:"
	localparam int KEY_LEN   = 15;
	localparam int KEY_SLOTS = 16;
	localparam int KP_W      = $clog2(KEY_SLOTS);

	localparam logic [7:0] KEY_TEXT [KEY_LEN] = '{
		8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
		8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A
	};

	// Characters of interest
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_0   = 8'h30;
	localparam logic [7:0] CH_9   = 8'h39;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef logic [LENGTH_BITS-1:0]   len_t;
	typedef logic [LENGTH_BITS+3:0]   acc_t;
	typedef logic [BLEN_W-1:0]        blen_t;
	typedef logic [3:0]               digit_t;
	typedef logic [KP_W-1:0]          kp_t;
	typedef logic [QPTR_W-1:0]        qptr_t;
	typedef logic [QCNT_W-1:0]        qcnt_t;

	// Classified byte handed from front to back
	typedef struct packed {
		logic [7:0]           data;
		logic                 is_cr;
		logic                 is_lf;
		logic                 is_blank;
		logic                 is_digit;
		digit_t               digit;
		logic [KEY_SLOTS-1:0] key_hit;
	} hrf_class_t;

	// Queue status
	typedef struct packed {
		logic full;
		logic empty;
	} hrf_qstat_t;

endpackage

[design/hrf_front.sv]
module hrf_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         data_byte,
	input  logic               in_valid,
	output logic               in_stall,
	input  hrf_pkg::hrf_qstat_t qstat,
	output hrf_pkg::hrf_class_t cls_s1,
	output logic               cls_valid_s1
);
	import hrf_pkg::*;

	hrf_class_t cls_c;
	logic       accept;
	logic       push;

	// Classify the incoming byte
	always_comb begin
		cls_c          = '0;
		cls_c.data     = data_byte;
		cls_c.is_cr    = (data_byte == CH_CR);
		cls_c.is_lf    = (data_byte == CH_LF);
		cls_c.is_blank = (data_byte == CH_SP) || (data_byte == CH_TAB);
		cls_c.is_digit = (data_byte >= CH_0) && (data_byte <= CH_9);
		cls_c.digit    = digit_t'(data_byte - CH_0);
		for (int i = 0; i < KEY_LEN; i++) begin
			cls_c.key_hit[i] = (data_byte == KEY_TEXT[i]);
		end
	end

	// Hold the stage while the queue is full
	assign push     = cls_valid_s1 && !qstat.full;
	assign in_stall = cls_valid_s1 && qstat.full;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cls_valid_s1 <= 1'b0;
		end else if (accept) begin
			cls_valid_s1 <= 1'b1;
		end else if (push) begin
			cls_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cls_s1 <= cls_c;
		end
	end

endmodule

[design/hrf_queue.sv]
module hrf_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_valid,
	input  hrf_pkg::hrf_class_t wr_data,
	input  logic                rd_ready,
	output hrf_pkg::hrf_class_t rd_data,
	output hrf_pkg::hrf_qstat_t qstat
);
	import hrf_pkg::*;

	hrf_class_t entries_q [QUEUE_DEPTH];
	qptr_t      wr_ptr_q;
	qptr_t      rd_ptr_q;
	qcnt_t      count_q;
	logic       push;
	logic       pop;

	assign qstat.full  = (count_q == qcnt_t'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign push        = wr_valid && !qstat.full;
	assign pop         = rd_ready && !qstat.empty;
	assign rd_data     = entries_q[rd_ptr_q];

	function automatic qptr_t ptr_inc(qptr_t p);
		return (p == qptr_t'(QUEUE_DEPTH - 1)) ? '0 : qptr_t'(p + 1'b1);
	endfunction

	// Store the written item
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   count_q <= qcnt_t'(count_q + 1'b1);
				2'b01:   count_q <= qcnt_t'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[design/hrf_back.sv]
module hrf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  hrf_pkg::hrf_class_t rd_data,
	input  hrf_pkg::hrf_qstat_t qstat,
	output logic                rd_ready,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          out_byte,
	output logic                request_last,
	output hrf_pkg::blen_t      body_length,
	output logic                length_saturated,
	output logic                in_body
);
	import hrf_pkg::*;

	typedef enum logic [1:0] {LP_KEY, LP_BLANK, LP_DIGIT, LP_DONE} lphase_t;
	typedef enum logic [1:0] {TP_NONE, TP_CR, TP_CRLF, TP_CRLFCR} tprog_t;

	tprog_t  tp_q,   tp_n;
	kp_t     kp_q,   kp_n;
	lphase_t lp_q,   lp_n;
	len_t    len_q,  len_n;
	logic    sat_q,  sat_n;
	len_t    rem_q,  rem_n;
	logic    body_q, body_n;

	logic  o_last, o_sat, o_body;
	blen_t o_blen;
	logic  term_done;
	logic  take;
	acc_t  acc;

	assign rd_ready = !out_valid || !out_stall;
	assign take     = rd_ready && !qstat.empty;

	// Length accumulate: value * 10 + digit, with carry bits kept for clamping
	assign acc = acc_t'({len_q, 3'b000}) + acc_t'({len_q, 1'b0}) + acc_t'(rd_data.digit);

	// Work out the next framing state for the byte at the queue head
	always_comb begin
		tp_n      = tp_q;
		kp_n      = kp_q;
		lp_n      = lp_q;
		len_n     = len_q;
		sat_n     = sat_q;
		rem_n     = rem_q;
		body_n    = body_q;
		o_last    = 1'b0;
		o_blen    = '0;
		o_sat     = 1'b0;
		o_body    = 1'b0;
		term_done = 1'b0;

		if (body_q) begin
			o_body = 1'b1;
			if (rem_q != '0) begin
				rem_n = len_t'(rem_q - 1'b1);
			end
			if (rem_n == '0) begin
				o_last = 1'b1;
				o_blen = blen_t'(len_q);
				o_sat  = sat_q;
				tp_n   = TP_NONE;
				kp_n   = '0;
				lp_n   = LP_KEY;
				len_n  = '0;
				sat_n  = 1'b0;
				body_n = 1'b0;
			end
		end else begin
			// Key search, blank skip and digit accumulate
			unique case (lp_q)
				LP_KEY: begin
					if (rd_data.key_hit[kp_q]) begin
						kp_n = kp_t'(kp_q + 1'b1);
					end else begin
						kp_n = rd_data.key_hit[0] ? kp_t'(1) : '0;
					end
					if (kp_n == kp_t'(KEY_LEN)) begin
						kp_n = '0;
						lp_n = LP_BLANK;
					end
				end
				LP_BLANK, LP_DIGIT: begin
					if (lp_q == LP_BLANK && rd_data.is_blank) begin
						lp_n = lp_q;
					end else if (rd_data.is_digit) begin
						lp_n = LP_DIGIT;
						if (sat_q || acc[LENGTH_BITS+3:LENGTH_BITS] != '0) begin
							len_n = '1;
							sat_n = 1'b1;
						end else begin
							len_n = acc[LENGTH_BITS-1:0];
						end
					end else begin
						lp_n = LP_DONE;
					end
				end
				default: lp_n = lp_q;
			endcase

			// Header terminator CR LF CR LF
			priority if (rd_data.is_cr) begin
				tp_n = (tp_q == TP_CRLF) ? TP_CRLFCR : TP_CR;
			end else if (rd_data.is_lf) begin
				priority if (tp_q == TP_CR) begin
					tp_n = TP_CRLF;
				end else if (tp_q == TP_CRLFCR) begin
					tp_n      = TP_NONE;
					term_done = 1'b1;
				end else begin
					tp_n = TP_NONE;
				end
			end else begin
				tp_n = TP_NONE;
			end

			if (term_done) begin
				if (len_n == '0) begin
					o_last = 1'b1;
					o_sat  = sat_n;
					tp_n   = TP_NONE;
					kp_n   = '0;
					lp_n   = LP_KEY;
					len_n  = '0;
					sat_n  = 1'b0;
					rem_n  = '0;
					body_n = 1'b0;
				end else begin
					body_n = 1'b1;
					rem_n  = len_n;
				end
			end
		end
	end

	// Hold state and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tp_q             <= TP_NONE;
			kp_q             <= '0;
			lp_q             <= LP_KEY;
			len_q            <= '0;
			sat_q            <= 1'b0;
			rem_q            <= '0;
			body_q           <= 1'b0;
			out_valid        <= 1'b0;
			out_byte         <= '0;
			request_last     <= 1'b0;
			body_length      <= '0;
			length_saturated <= 1'b0;
			in_body          <= 1'b0;
		end else if (take) begin
			tp_q             <= tp_n;
			kp_q             <= kp_n;
			lp_q             <= lp_n;
			len_q            <= len_n;
			sat_q            <= sat_n;
			rem_q            <= rem_n;
			body_q           <= body_n;
			out_valid        <= 1'b1;
			out_byte         <= rd_data.data;
			request_last     <= o_last;
			body_length      <= o_blen;
			length_saturated <= o_sat;
			in_body          <= o_body;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

endmodule

[design/http_request_framer_core.sv]
// An accepted byte passes the front register, the queue and then the output register.
// Throughput: one byte per cycle while no output stall or full queue holds the flow;
// the back end updates all framing state (key match, length accumulate, body count)
// together for each byte it takes.
// A 4-entry queue lets the input keep flowing for a while under output stall.
// Reset (arst_n low, asynchronous) clears framing state, queue and valid flags.
`include "http_request_framer_core_macros.svh"

module http_request_framer_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     data_byte,
	input  logic           in_valid,
	output logic           in_stall,
	output logic [7:0]     out_byte,
	output logic           request_last,
	output hrf_pkg::blen_t body_length,
	output logic           length_saturated,
	output logic           in_body,
	output logic           out_valid,
	input  logic           out_stall
);
	import hrf_pkg::*;

	hrf_class_t fr_cls_s1;
	logic       fr_valid_s1;
	hrf_class_t q_rd_data;
	hrf_qstat_t qstat;
	logic       q_rd_ready;

	// Accept and classify bytes
	hrf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_byte    (data_byte),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.qstat        (qstat),
		.cls_s1       (fr_cls_s1),
		.cls_valid_s1 (fr_valid_s1)
	);

	// Decouple front from back
	hrf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fr_valid_s1),
		.wr_data  (fr_cls_s1),
		.rd_ready (q_rd_ready),
		.rd_data  (q_rd_data),
		.qstat    (qstat)
	);

	// Frame requests and drive results
	hrf_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.rd_data          (q_rd_data),
		.qstat            (qstat),
		.rd_ready         (q_rd_ready),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.out_byte         (out_byte),
		.request_last     (request_last),
		.body_length      (body_length),
		.length_saturated (length_saturated),
		.in_body          (in_body)
	);

	`HRF_ASSERT_IMP(a_len_only_last, out_valid && !request_last, body_length == '0 && !length_saturated)
	`HRF_ASSERT_IMP(a_hdr_end_zero, out_valid && request_last && !in_body, body_length == '0 && !length_saturated)
	`HRF_ASSERT_IMP(a_queue_sane, 1'b1, !(qstat.full && qstat.empty))
	`HRF_ASSERT_NXT(a_front_loaded, in_valid && !in_stall, fr_valid_s1)

endmodule

[tb/sv/http_frame_checker.sv]
module http_frame_checker
	import hrf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  data_byte,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  out_byte,
	input  logic        request_last,
	input  blen_t       body_length,
	input  logic        length_saturated,
	input  logic        in_body,
	input  logic        out_valid,
	input  logic        out_stall,
	output int unsigned fail_count,
	output int unsigned outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {
		SEEK_KEY,
		SKIP_BLANKS,
		READ_DIGITS,
		DIGITS_DONE
	} length_scan_e;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		blen_t      blen;
		logic       sat;
		logic       body;
	} framed_byte_t;

	localparam logic [LENGTH_BITS-1:0] LEN_CEILING = '1;

	// Framing state of the request being parsed
	logic [1:0]             crlf_seen;
	int unsigned            key_seen;
	length_scan_e           scan;
	logic [LENGTH_BITS-1:0] len_acc;
	logic                   len_clamped;
	logic [LENGTH_BITS-1:0] body_left;
	logic                   in_payload;

	framed_byte_t           framed_bytes [$];
	int unsigned            errors = 0;

	function automatic void restart_request();
		crlf_seen   = '0;
		key_seen    = 0;
		scan        = SEEK_KEY;
		len_acc     = '0;
		len_clamped = 1'b0;
		body_left   = '0;
		in_payload  = 1'b0;
	endfunction

	// Advance the framing state by one byte and return what the block should emit
	function automatic framed_byte_t frame_byte(input logic [7:0] b);
		framed_byte_t           r;
		logic [LENGTH_BITS+3:0] grown;
		logic                   hdr_end;
		r      = '0;
		r.data = b;
		hdr_end = 1'b0;
		if (in_payload) begin
			// count down the body, close the request on its last byte
			r.body = 1'b1;
			if (body_left != 0)
				body_left = body_left - 1'b1;
			if (body_left == 0) begin
				r.last = 1'b1;
				r.blen = blen_t'(len_acc);
				r.sat  = len_clamped;
				restart_request();
			end
		end else begin
			// look for the key, then blanks, then digits
			case (scan)
				SEEK_KEY: begin
					if (key_seen < KEY_LEN && b == KEY_TEXT[key_seen])
						key_seen++;
					else
						key_seen = (b == KEY_TEXT[0]) ? 1 : 0;
					if (key_seen >= KEY_LEN) begin
						key_seen = 0;
						scan     = SKIP_BLANKS;
					end
				end
				SKIP_BLANKS, READ_DIGITS: begin
					if (b >= CH_0 && b <= CH_9) begin
						scan  = READ_DIGITS;
						grown = len_acc * 10 + (b - CH_0);
						if (len_clamped || grown > LEN_CEILING) begin
							len_acc     = LEN_CEILING;
							len_clamped = 1'b1;
						end else begin
							len_acc = grown[LENGTH_BITS-1:0];
						end
					end else if (!(scan == SKIP_BLANKS && (b == CH_SP || b == CH_TAB))) begin
						scan = DIGITS_DONE;
					end
				end
				default: ;
			endcase

			// track CR LF CR LF
			if (b == CH_CR) begin
				crlf_seen = (crlf_seen == 2) ? 2'd3 : 2'd1;
			end else if (b == CH_LF) begin
				if (crlf_seen == 1) begin
					crlf_seen = 2'd2;
				end else if (crlf_seen == 3) begin
					crlf_seen = '0;
					hdr_end   = 1'b1;
				end else begin
					crlf_seen = '0;
				end
			end else begin
				crlf_seen = '0;
			end

			// end of headers: finish now or move into the body
			if (hdr_end) begin
				if (len_acc == 0) begin
					r.last = 1'b1;
					r.sat  = len_clamped;
					restart_request();
				end else begin
					in_payload = 1'b1;
					body_left  = len_acc;
				end
			end
		end
		return r;
	endfunction

	function automatic int field_differs(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	// Compare each output item with the oldest prediction, then predict the input item
	always @(posedge clk or negedge arst_n) begin
		framed_byte_t want;
		if (!arst_n) begin
			restart_request();
			framed_bytes.delete();
			fail_count  <= errors;
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (framed_bytes.size() == 0) begin
					$error("output item %0h with no prediction pending", out_byte);
					errors++;
				end else begin
					want = framed_bytes.pop_front();
					errors += field_differs("out_byte", want.data, out_byte)
						+ field_differs("request_last", want.last, request_last)
						+ field_differs("body_length", want.blen, body_length)
						+ field_differs("length_saturated", want.sat, length_saturated)
						+ field_differs("in_body", want.body, in_body);
				end
			end
			if (in_valid && !in_stall)
				framed_bytes.push_back(frame_byte(data_byte));
			fail_count  <= errors;
			outstanding <= framed_bytes.size();
		end
	end

endmodule

[tb/sv/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import hrf_pkg::*;

	localparam int DRAIN_CYCLES = 8;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic [7:0]  data_byte  = '0;
	logic        in_valid   = 1'b0;
	logic        in_stall;
	logic [7:0]  out_byte;
	logic        request_last;
	blen_t       body_length;
	logic        length_saturated;
	logic        in_body;
	logic        out_valid;
	logic        out_stall  = 1'b0;

	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned bytes_sent = 0;
	bit          steady     = 1'b0;

	always #4 clk = ~clk;

	http_request_framer_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.data_byte        (data_byte),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.out_byte         (out_byte),
		.request_last     (request_last),
		.body_length      (body_length),
		.length_saturated (length_saturated),
		.in_body          (in_body),
		.out_valid        (out_valid),
		.out_stall        (out_stall)
	);

	http_frame_checker checker_i (
		.clk              (clk),
		.arst_n           (arst_n),
		.data_byte        (data_byte),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.out_byte         (out_byte),
		.request_last     (request_last),
		.body_length      (body_length),
		.length_saturated (length_saturated),
		.in_body          (in_body),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.fail_count       (fail_count),
		.outstanding      (outstanding)
	);

	// Offer one byte after a random gap and hold it until accepted
	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		data_byte <= b;
		in_valid  <= 1'b1;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_eol();
		send_byte(CH_CR);
		send_byte(CH_LF);
	endtask

	// Short printable header line
	task automatic send_filler();
		repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(8'h21, 8'h7E)));
		send_eol();
	endtask

	// Length header in one of several shapes; value is what it should parse to
	task automatic send_key_line(output int unsigned value);
		int unsigned form;
		form  = $urandom_range(0, 5);
		value = (form == 0) ? 0 : $urandom_range(0, 40);
		send_text("Content-Length:");
		repeat ($urandom_range(0, 2)) send_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
		if (form == 1)
			send_byte(CH_0);
		if (form != 0)
			send_text($sformatf("%0d", value));
		if (form >= 4)
			send_text(";q");
		send_eol();
	endtask

	// Drop valid and hold off until every predicted item has come out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Receiver: stall a random number of cycles before each item
	initial begin
		int unsigned hold;
		forever begin
			hold = steady ? 0 : $urandom_range(0, 4);
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Stimulus and verdict
	initial begin
		int unsigned n_fill;
		int unsigned key_at;
		int unsigned blen;
		int unsigned spare;
		bit          has_key;
		bit          paused;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extreme byte values, then an empty header block
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h80);
		send_byte(8'h7F);
		send_eol();
		send_eol();
		// key followed by a non-digit
		send_text("Content-Length:x");
		send_eol();
		send_eol();
		// blanks before the digits, a second key, body holding CR LF
		send_text("Content-Length: ");
		send_byte(CH_TAB);
		send_text("3");
		send_eol();
		send_text("Content-Length:9");
		send_eol();
		send_eol();
		send_eol();
		send_byte(8'h41);
		// explicit zero length
		send_text("Content-Length:0");
		send_eol();
		send_eol();
		drain();

		// random requests with some noise between them
		bytes_sent = 0;
		paused     = 1'b0;
		while (bytes_sent < 600) begin
			steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 5) == 0) begin
				case ($urandom_range(0, 2))
					0: repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
					1: send_text("Content-Len");
					default: begin
						send_eol();
						send_byte(CH_CR);
						send_byte(CH_CR);
						send_byte(CH_LF);
						send_byte(CH_LF);
					end
				endcase
			end

			send_filler();
			has_key = ($urandom_range(0, 4) != 0);
			n_fill  = $urandom_range(0, 2);
			key_at  = $urandom_range(0, n_fill);
			blen    = 0;
			for (int i = 0; i <= n_fill; i++) begin
				if (has_key && i == key_at)
					send_key_line(blen);
				if (i < n_fill)
					send_filler();
			end
			if (has_key && $urandom_range(0, 4) == 0)
				send_key_line(spare);
			send_eol();
			repeat (blen) send_byte(8'($urandom_range(0, 255)));

			if (!paused && bytes_sent >= 300) begin
				drain();
				paused = 1'b1;
			end
		end

		// oversized length last: it clamps, and the body never ends within the run
		steady = 1'b0;
		send_text("Content-Length:429496729677");
		send_eol();
		send_eol();
		repeat (16) send_byte(8'($urandom_range(0, 255)));
		drain();

		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Give up if the run hangs
	initial begin
		#1_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[filelist.f]
+incdir+design
design/hrf_pkg.sv
design/hrf_front.sv
design/hrf_queue.sv
design/hrf_back.sv
design/http_request_framer_core.sv
tb/sv/http_frame_checker.sv
tb/sv/tb_top.sv
